>>> rtl/igmp_host_membership_engine_macros.svh
// Assertion macros for the IGMP host membership engine.
`ifndef IGMP_HOST_MEMBERSHIP_ENGINE_MACROS_SVH
`define IGMP_HOST_MEMBERSHIP_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define IHME_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IHME_ASSERT_NORST(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IHME_ASSERT(lbl, clk, rst_n, prop, msg)
`define IHME_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/ihme_pkg.sv
// Package with types, codes and constants of the IGMP host membership engine.
package ihme_pkg;
	localparam int GROUP_SLOTS_DEF = 16;
	localparam logic [7:0] TYPE_QUERY = 8'h11;
	localparam logic [7:0] TYPE_REPORT = 8'h12;
	localparam logic [31:0] LFSR_MASK = 32'h8020_0003;
	localparam logic [31:0] LFSR_SEED = 32'h0000_0001;
	localparam logic [15:0] MIN_MSG_LEN = 16'd8;
	localparam logic [7:0] MAX_DELAY_RESET = 8'd50;
	localparam logic [31:0] ALL_HOSTS_RESET = 32'hE000_0001;

	typedef enum logic [1:0] {
		KIND_PACKET = 2'd0,
		KIND_JOIN = 2'd1,
		KIND_LEAVE = 2'd2,
		KIND_TICK = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_OK = 4'd0,
		ST_SHORT = 4'd1,
		ST_BADSUM = 4'd2,
		ST_BADQUERY = 4'd3,
		ST_BADREPORT = 4'd4,
		ST_UNKNOWN = 4'd5,
		ST_OURREPORT = 4'd6,
		ST_TABLEFULL = 4'd7,
		ST_LOOPBACK = 4'd8
	} status_t;

	typedef enum logic [1:0] {
		REG_LOOPBACK = 2'd0,
		REG_MAX_DELAY = 2'd1,
		REG_ALL_HOSTS = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_DIV,
		S_DIV_DONE,
		S_JOIN,
		S_EMIT_RPT,
		S_EMIT_ST
	} state_t;

	// Handshake between sequencer and the shared remainder unit.
	typedef struct packed {
		logic start;
		logic [31:0] dividend;
		logic [7:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [7:0] rem;
	} div_rsp_t;
endpackage

>>> rtl/ihme_rem_unit.sv
// Bit-serial remainder unit: 32-bit dividend modulo an 8-bit divisor.
module ihme_rem_unit import ihme_pkg::*; (
	input logic clk,
	input logic arst_n,
	input div_req_t req,
	output div_rsp_t rsp
);
	logic [31:0] dvd_q;
	logic [7:0] dvs_q;
	logic [8:0] rem_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [8:0] shifted;
	logic [8:0] trial;

	always_comb begin
		shifted = {rem_q[7:0], dvd_q[31]};
		trial = shifted - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			rem_q <= trial[8] ? shifted : trial;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.rem = rem_q[7:0];
endmodule

>>> rtl/ihme_slot_table.sv
// Register table of joined group slots with one read port chosen by index.
module ihme_slot_table import ihme_pkg::*; #(
	parameter int GROUP_SLOTS = GROUP_SLOTS_DEF,
	localparam int IW = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1
) (
	input logic clk,
	input logic arst_n,
	input logic [IW-1:0] idx,
	input logic wr_valid_en,
	input logic wr_valid,
	input logic wr_group_en,
	input logic [31:0] wr_group,
	input logic wr_timer_en,
	input logic [7:0] wr_timer,
	output logic rd_valid,
	output logic [31:0] rd_group,
	output logic [7:0] rd_timer
);
	logic [GROUP_SLOTS-1:0] valid_q;
	logic [31:0] group_q [GROUP_SLOTS];
	logic [7:0] timer_q [GROUP_SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < GROUP_SLOTS; i++) timer_q[i] <= '0;
		end else begin
			if (wr_valid_en) valid_q[idx] <= wr_valid;
			if (wr_timer_en) timer_q[idx] <= wr_timer;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_group_en) group_q[idx] <= wr_group;
	end

	assign rd_valid = valid_q[idx];
	assign rd_group = group_q[idx];
	assign rd_timer = timer_q[idx];
endmodule

>>> rtl/igmp_host_membership_engine.sv
// Top level of the IGMPv1 host membership engine: sequencer, registers, ports.
//
//  channel | direction | beat content
//  in      | input     | kind, msg_type, group_addr, dest_addr, msg_length, checksum_ok
//  out     | output    | result_kind, status, report_group, pass_up, last
//  apb     | input     | is_loopback, max_delay_ticks, all_hosts_group at 0x0, 0x4, 0x8
//
// A rejected packet, a loopback packet and an idle tick go from S_DECODE straight to the
// status beat. A leave, a report and a busy tick walk every slot, one per cycle unless a
// tick holds on a pending output beat; a join walks the slots, then passes S_JOIN and, when
// it sends a report, S_EMIT_RPT, S_DIV and S_DIV_DONE. Each drawn delay passes S_DIV and
// the bit-serial remainder unit, and each expiring timer adds an S_EMIT_RPT state.
// Reset clears the slot valid bits and timers at once; no clearing pass is needed.
// in_stall is high while an item is at work; an output beat holds while out_stall is high.
`include "igmp_host_membership_engine_macros.svh"
module igmp_host_membership_engine import ihme_pkg::*; #(
	parameter int GROUP_SLOTS = GROUP_SLOTS_DEF,
	localparam int IW = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] kind,
	input logic [7:0] msg_type,
	input logic [31:0] group_addr,
	input logic [31:0] dest_addr,
	input logic [15:0] msg_length,
	input logic checksum_ok,
	output logic out_valid,
	input logic out_stall,
	output logic result_kind,
	output logic [3:0] status,
	output logic [31:0] report_group,
	output logic pass_up,
	output logic last
);
	localparam logic [IW-1:0] LAST_IDX = IW'(GROUP_SLOTS - 1);

	// Configuration registers.
	logic loop_q;
	logic [7:0] maxd_q;
	logic [31:0] ahg_q;
	reg_idx_t ridx;
	assign ridx = reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_q <= 1'b0;
			maxd_q <= MAX_DELAY_RESET;
			ahg_q <= ALL_HOSTS_RESET;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			unique case (ridx)
				REG_LOOPBACK: loop_q <= pwdata[0];
				REG_MAX_DELAY: maxd_q <= pwdata[7:0];
				REG_ALL_HOSTS: ahg_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			unique case (ridx)
				REG_LOOPBACK: prdata = {31'd0, loop_q};
				REG_MAX_DELAY: prdata = {24'd0, maxd_q};
				REG_ALL_HOSTS: prdata = ahg_q;
				default: prdata = '0;
			endcase
		end
	end

	// Item registers.
	state_t state_q, state_d;
	kind_t kind_q;
	logic [7:0] type_q;
	logic [31:0] grp_q, dst_q;
	logic [15:0] len_q;
	logic csum_q;
	logic [IW-1:0] idx_q;
	logic found_q;
	logic free_q;
	logic [IW-1:0] free_idx_q;
	logic run_q;
	logic run_next_q;
	logic [31:0] lfsr_q;
	status_t st_q;
	logic pass_q;
	logic [31:0] rpt_grp_q;
	logic ov_q;
	logic orpt_q;
	logic [3:0] ost_q;
	logic [31:0] ogrp_q;
	logic opass_q;
	logic olast_q;

	// Slot table.
	logic [IW-1:0] t_idx;
	logic t_wv_en, t_wv, t_wg_en, t_wt_en;
	logic [7:0] t_wt;
	logic rd_valid;
	logic [31:0] rd_group;
	logic [7:0] rd_timer;

	ihme_slot_table #(.GROUP_SLOTS(GROUP_SLOTS)) u_table (
		.clk(clk), .arst_n(arst_n), .idx(t_idx),
		.wr_valid_en(t_wv_en), .wr_valid(t_wv),
		.wr_group_en(t_wg_en), .wr_group(grp_q),
		.wr_timer_en(t_wt_en), .wr_timer(t_wt),
		.rd_valid(rd_valid), .rd_group(rd_group), .rd_timer(rd_timer)
	);

	div_req_t dreq;
	div_rsp_t drsp;
	ihme_rem_unit u_rem (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic in_acc, out_acc;
	assign in_acc = in_valid && !in_stall;
	assign out_acc = ov_q && !out_stall;
	assign in_stall = (state_q != S_IDLE);

	logic q_ok, r_ok, is_query, is_report, pkt_ok, last_slot;
	logic [7:0] bound;
	logic [7:0] delay;
	assign bound = (maxd_q == 8'd0) ? 8'd1 : maxd_q;
	assign delay = drsp.rem + 8'd1;
	assign pkt_ok = (len_q >= MIN_MSG_LEN) && csum_q;
	assign is_query = pkt_ok && type_q == TYPE_QUERY && !loop_q && dst_q == ahg_q;
	assign is_report = pkt_ok && type_q == TYPE_REPORT && !loop_q
		&& grp_q[31:28] == 4'hE && grp_q == dst_q;
	assign last_slot = (idx_q == LAST_IDX);
	// A query slot that needs a delay drawn.
	assign q_ok = rd_valid && rd_timer == 8'd0 && rd_group != ahg_q;
	// A tick slot whose timer runs out now.
	assign r_ok = rd_valid && rd_timer == 8'd1;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_acc) state_d = S_DECODE;
			S_DECODE: begin
				priority if (kind_q == KIND_PACKET && !is_query && !is_report)
					state_d = S_EMIT_ST;
				else if (kind_q == KIND_TICK && !run_q) state_d = S_EMIT_ST;
				else state_d = S_SCAN;
			end
			S_SCAN: begin
				priority if (kind_q == KIND_PACKET && is_query && q_ok) state_d = S_DIV;
				else if (kind_q == KIND_TICK && r_ok && !ov_q) state_d = S_EMIT_RPT;
				else if (kind_q == KIND_TICK && r_ok) state_d = S_SCAN;
				else if (last_slot) state_d = (kind_q == KIND_JOIN) ? S_JOIN : S_EMIT_ST;
				else state_d = S_SCAN;
			end
			S_DIV: state_d = S_DIV_DONE;
			S_DIV_DONE: if (drsp.done)
				state_d = (last_slot || kind_q == KIND_JOIN) ? S_EMIT_ST : S_SCAN;
			S_JOIN: begin
				if (!found_q && free_q && grp_q != ahg_q && !loop_q && !ov_q)
					state_d = S_EMIT_RPT;
				else if (!found_q && free_q && grp_q != ahg_q && !loop_q) state_d = S_JOIN;
				else state_d = S_EMIT_ST;
			end
			S_EMIT_RPT: state_d = (kind_q == KIND_JOIN) ? S_DIV : (last_slot ? S_EMIT_ST : S_SCAN);
			S_EMIT_ST: if (!ov_q) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Table and divider control.
	always_comb begin
		t_idx = idx_q;
		t_wv_en = 1'b0;
		t_wv = 1'b0;
		t_wg_en = 1'b0;
		t_wt_en = 1'b0;
		t_wt = '0;
		dreq.start = 1'b0;
		dreq.dividend = grp_q;
		dreq.divisor = bound;
		unique case (state_q)
			S_SCAN: begin
				if (kind_q == KIND_TICK && rd_valid && rd_timer != 8'd0
					&& !(r_ok && ov_q)) begin
					t_wt_en = 1'b1;
					t_wt = rd_timer - 8'd1;
				end else if (kind_q == KIND_PACKET && is_report && rd_valid
					&& rd_group == grp_q) begin
					t_wt_en = 1'b1;
				end else if (kind_q == KIND_LEAVE && rd_valid && rd_group == grp_q) begin
					t_wv_en = 1'b1;
					t_wt_en = 1'b1;
				end
			end
			S_DIV: begin
				// A join draws from its own group, a query from the slot it stopped at.
				dreq.start = 1'b1;
				dreq.dividend = ((kind_q == KIND_JOIN) ? grp_q : rd_group) ^ lfsr_q;
				if (kind_q == KIND_JOIN) t_idx = free_idx_q;
			end
			S_DIV_DONE: begin
				if (kind_q == KIND_JOIN) t_idx = free_idx_q;
				if (drsp.done) begin
					t_wt_en = 1'b1;
					t_wt = delay;
				end
			end
			S_JOIN: begin
				t_idx = free_idx_q;
				if (!found_q && free_q && !(grp_q != ahg_q && !loop_q && ov_q)) begin
					t_wv_en = 1'b1;
					t_wv = 1'b1;
					t_wg_en = 1'b1;
					t_wt_en = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			run_q <= 1'b0;
			run_next_q <= 1'b0;
			lfsr_q <= LFSR_SEED;
			ov_q <= 1'b0;
			idx_q <= '0;
			found_q <= 1'b0;
			free_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_acc) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					found_q <= 1'b0;
					free_q <= 1'b0;
					run_next_q <= 1'b0;
				end
				S_SCAN: begin
					if (kind_q == KIND_JOIN && rd_valid && rd_group == grp_q) found_q <= 1'b1;
					if (kind_q == KIND_JOIN && !rd_valid && !free_q) free_q <= 1'b1;
					if (kind_q == KIND_TICK && rd_valid && rd_timer > 8'd1)
						run_next_q <= 1'b1;
					if (!(kind_q == KIND_PACKET && is_query && q_ok)
						&& !(kind_q == KIND_TICK && r_ok) && !last_slot)
						idx_q <= idx_q + IW'(1);
					if (kind_q == KIND_TICK && last_slot && !r_ok)
						run_q <= run_next_q || (rd_valid && rd_timer > 8'd1);
				end
				S_DIV_DONE: begin
					if (drsp.done) begin
						lfsr_q <= (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_MASK : 32'd0);
						run_q <= 1'b1;
						if (!last_slot && kind_q != KIND_JOIN) idx_q <= idx_q + IW'(1);
					end
				end
				S_EMIT_RPT: begin
					ov_q <= 1'b1;
					if (kind_q == KIND_TICK) begin
						if (last_slot) run_q <= run_next_q;
						else idx_q <= idx_q + IW'(1);
					end
				end
				S_EMIT_ST: if (!ov_q) ov_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q <= kind_t'(kind);
			type_q <= msg_type;
			grp_q <= group_addr;
			dst_q <= dest_addr;
			len_q <= msg_length;
			csum_q <= checksum_ok;
		end
		if (state_q == S_SCAN && kind_q == KIND_JOIN && !rd_valid && !free_q)
			free_idx_q <= idx_q;
		if (state_q == S_SCAN) rpt_grp_q <= rd_group;
		if (state_q == S_JOIN) rpt_grp_q <= grp_q;
		if (state_q == S_DECODE) begin
			pass_q <= 1'b0;
			st_q <= ST_OK;
			if (kind_q == KIND_PACKET) begin
				priority if (len_q < MIN_MSG_LEN) st_q <= ST_SHORT;
				else if (!csum_q) st_q <= ST_BADSUM;
				else if (type_q == TYPE_QUERY) begin
					pass_q <= loop_q || dst_q == ahg_q;
					st_q <= loop_q ? ST_LOOPBACK : (dst_q == ahg_q ? ST_OK : ST_BADQUERY);
				end else if (type_q == TYPE_REPORT) begin
					pass_q <= loop_q || is_report;
					st_q <= loop_q ? ST_LOOPBACK : (is_report ? ST_OK : ST_BADREPORT);
				end else st_q <= ST_UNKNOWN;
			end
		end
		if (state_q == S_SCAN && kind_q == KIND_PACKET && is_report && rd_valid
			&& rd_group == grp_q) st_q <= ST_OURREPORT;
		if (state_q == S_JOIN && !found_q && !free_q) st_q <= ST_TABLEFULL;
		if (state_q == S_EMIT_RPT) begin
			orpt_q <= 1'b1;
			ost_q <= ST_OK;
			ogrp_q <= rpt_grp_q;
			opass_q <= 1'b0;
			olast_q <= 1'b0;
		end
		if (state_q == S_EMIT_ST && !ov_q) begin
			orpt_q <= 1'b0;
			ost_q <= st_q;
			ogrp_q <= '0;
			opass_q <= pass_q;
			olast_q <= 1'b1;
		end
	end

	assign out_valid = ov_q;
	assign result_kind = orpt_q;
	assign status = ost_q;
	assign report_group = ogrp_q;
	assign pass_up = opass_q;
	assign last = olast_q;

	`IHME_ASSERT(a_no_accept_busy, clk, arst_n, in_acc |-> state_q == S_IDLE, "accept while busy")
	`IHME_ASSERT(a_lfsr_nz, clk, arst_n, lfsr_q != 32'd0, "lfsr became zero")
	`IHME_ASSERT(a_emit_free, clk, arst_n, state_q == S_EMIT_RPT |-> !ov_q, "output overwritten")
	`IHME_ASSERT(a_div_start, clk, arst_n, dreq.start |-> !drsp.busy, "divider restarted")
endmodule
